@@ hdl/assert_macros.svh @@
// Assertion macros for the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the active-low reset is low
`define G2E_ASSERT_CLK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (prop)) else $error(msg);

// Same check on the default clk and rst_n
`define G2E_ASSERT(lbl, prop, msg) \
  `G2E_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

@@ hdl/g2e_pkg.sv @@
// Types, constants and helpers for the geodetic to ENU converter
`timescale 1ns / 1ps

package g2e_pkg;

  typedef enum logic [1:0] {
    CFG_REF_LAT = 2'd0,
    CFG_REF_LON = 2'd1,
    CFG_REF_ALT = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [32:0] s;
    logic signed [32:0] c;
  } trig_t;

  typedef struct packed {
    trig_t              lat;
    trig_t              lon;
    logic signed [27:0] h;
  } side_t;

  typedef struct packed {
    logic [34:0] up;
    logic [34:0] north;
    logic [34:0] east;
  } res_t;

  localparam logic [31:0]        DEG7_TURN   = 32'd3600000000;
  // ceil(2^76 / 3515625): exact reciprocal for the 54-bit angle numerator
  localparam logic [108:0]       BAM_RECIP   = ((109'd1 << 76) + 109'd3515624) / 109'd3515625;
  localparam logic [26:0]        BAM_K_HI    = BAM_RECIP[54:28];
  localparam logic [27:0]        BAM_K_LO    = BAM_RECIP[27:0];
  localparam logic [108:0]       BAM_BIAS    = BAM_RECIP * 109'd1757812;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [24:0]        E2_Q32      = 25'd28752143;
  localparam logic [32:0]        A_MM        = 33'd6378137000;
  localparam int                 SQRT_STEPS  = 32;
  localparam int                 NDIV_BITS   = 33;
  localparam int                 ECEF_LAT    = SQRT_STEPS + NDIV_BITS + 5;
  localparam logic signed [39:0] OUT_LIMIT   = 40'sd13000000000;

  localparam logic [29:0] ATAN_TURN32 [48] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0,
    30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0,
    30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0
  };

  // round(a * q / 2^30), halves upward
  function automatic logic signed [39:0] mulq(logic signed [39:0] a,
                                              logic signed [33:0] q);
    logic signed [73:0] p;
    p = a * q + 74'sd536870912;
    return p[69:30];
  endfunction

  function automatic logic [34:0] sat35(logic signed [39:0] v);
    logic signed [39:0] t;
    t = v;
    if (v > OUT_LIMIT) t = OUT_LIMIT;
    if (v < -OUT_LIMIT) t = -OUT_LIMIT;
    return t[34:0];
  endfunction

endpackage

@@ hdl/geodetic_to_enu.sv @@
// WGS84 geodetic position to local east/north/up offsets, top level
//
// Input beats carry latitude and longitude in 1e-7 degree and ellipsoidal
// height in mm; each accepted beat gives one output beat with east, north
// and up offsets in mm from the reference position, saturated at
// +/-13000000000. The reference must be written through the cfg port while
// the block is idle; the block itself does not enforce this. A new reference
// takes effect for the next accepted beat. The datapath is a fixed pipeline of
// CORDIC_STAGES + 76 stages: a reciprocal multiply that turns degrees into a
// binary angle, the CORDIC cell row, a 32-cell square-root row and a 33-cell
// divider for the prime vertical radius, then ECEF and rotation multiplier
// stages. One beat is taken every cycle while the output side keeps up.
// A two-entry output buffer parts the sides: in_tready falls, and the whole
// pipeline holds, only while both entries wait to be taken.
// Reset clears the pipeline valid bits, the output buffer and the reference
// registers (reference position 0, 0, 0).
`timescale 1ns / 1ps

module geodetic_to_enu import g2e_pkg::*; #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // latitude[30:0], longitude[62:31], altitude[90:63]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // east[34:0], north[69:35], up[104:70]
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  `include "assert_macros.svh"

  localparam int TRIG_LAT = CORDIC_STAGES + 4;
  localparam int PIPE_LAT = TRIG_LAT + ECEF_LAT + 2;

  logic signed [30:0] ref_lat_r;
  logic signed [31:0] ref_lon_r;
  logic signed [27:0] ref_alt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r <= '0;
      ref_lon_r <= '0;
      ref_alt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REF_LAT: ref_lat_r <= cfg_wdata[30:0];
        CFG_REF_LON: ref_lon_r <= cfg_wdata;
        CFG_REF_ALT: ref_alt_r <= cfg_wdata[27:0];
        default: ;
      endcase
    end
  end

  logic [1:0] cnt_r, cnt_nxt;
  logic       en, push, pop;
  logic       v_r [PIPE_LAT];

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_LAT; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_tvalid;
      for (int k = 1; k < PIPE_LAT; k++) v_r[k] <= v_r[k-1];
    end
  end

  // heights wait for the angle units
  logic signed [27:0] hp_r [TRIG_LAT];
  logic signed [27:0] hr_r [TRIG_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      hp_r[0] <= in_tdata[90:63];
      hr_r[0] <= ref_alt_r;
      for (int k = 1; k < TRIG_LAT; k++) begin
        hp_r[k] <= hp_r[k-1];
        hr_r[k] <= hr_r[k-1];
      end
    end
  end

  trig_t la, lo, la0, lo0, la0_d, lo0_d;

  g2e_trig #(.STAGES(CORDIC_STAGES)) u_trig_lat (
    .clk, .en, .deg7(32'($signed(in_tdata[30:0]))), .trig(la)
  );
  g2e_trig #(.STAGES(CORDIC_STAGES)) u_trig_lon (
    .clk, .en, .deg7($signed(in_tdata[62:31])), .trig(lo)
  );
  g2e_trig #(.STAGES(CORDIC_STAGES)) u_trig_rlat (
    .clk, .en, .deg7(32'(ref_lat_r)), .trig(la0)
  );
  g2e_trig #(.STAGES(CORDIC_STAGES)) u_trig_rlon (
    .clk, .en, .deg7(ref_lon_r), .trig(lo0)
  );

  logic signed [35:0] px, py, pz, qx, qy, qz;

  g2e_ecef u_ecef_pt (
    .clk, .en, .lat(la), .lon(lo), .h(hp_r[TRIG_LAT-1]),
    .px(px), .py(py), .pz(pz), .lat_o(), .lon_o()
  );
  g2e_ecef u_ecef_ref (
    .clk, .en, .lat(la0), .lon(lo0), .h(hr_r[TRIG_LAT-1]),
    .px(qx), .py(qy), .pz(qz), .lat_o(la0_d), .lon_o(lo0_d)
  );

  // difference and rotation matrix
  logic signed [36:0] d_r [3];
  logic signed [33:0] cf_r [8];
  logic signed [37:0] t_r [8];

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]  <= 37'(px) - 37'(qx);
      d_r[1]  <= 37'(py) - 37'(qy);
      d_r[2]  <= 37'(pz) - 37'(qz);
      cf_r[0] <= -34'(lo0_d.s);
      cf_r[1] <= 34'(lo0_d.c);
      cf_r[2] <= -34'(mulq(40'(la0_d.s), 34'(lo0_d.c)));
      cf_r[3] <= -34'(mulq(40'(la0_d.s), 34'(lo0_d.s)));
      cf_r[4] <= 34'(la0_d.c);
      cf_r[5] <= 34'(mulq(40'(la0_d.c), 34'(lo0_d.c)));
      cf_r[6] <= 34'(mulq(40'(la0_d.c), 34'(lo0_d.s)));
      cf_r[7] <= 34'(la0_d.s);
      t_r[0]  <= 38'(mulq(40'(d_r[0]), cf_r[0]));
      t_r[1]  <= 38'(mulq(40'(d_r[1]), cf_r[1]));
      t_r[2]  <= 38'(mulq(40'(d_r[0]), cf_r[2]));
      t_r[3]  <= 38'(mulq(40'(d_r[1]), cf_r[3]));
      t_r[4]  <= 38'(mulq(40'(d_r[2]), cf_r[4]));
      t_r[5]  <= 38'(mulq(40'(d_r[0]), cf_r[5]));
      t_r[6]  <= 38'(mulq(40'(d_r[1]), cf_r[6]));
      t_r[7]  <= 38'(mulq(40'(d_r[2]), cf_r[7]));
    end
  end

  logic signed [39:0] e_sum, n_sum, u_sum;
  res_t               res_new, slot0_r, slot1_r, slot0_nxt, slot1_nxt;

  always_comb begin
    e_sum         = 40'(t_r[0]) + 40'(t_r[1]);
    n_sum         = 40'(t_r[2]) + 40'(t_r[3]) + 40'(t_r[4]);
    u_sum         = 40'(t_r[5]) + 40'(t_r[6]) + 40'(t_r[7]);
    res_new.east  = sat35(e_sum);
    res_new.north = sat35(n_sum);
    res_new.up    = sat35(u_sum);
  end

  // two-entry output buffer
  assign push = en && v_r[PIPE_LAT-1];
  assign pop  = out_tvalid && out_tready;

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    priority if (push && pop) begin
      slot0_nxt = (cnt_r == 2'd1) ? res_new : slot1_r;
      slot1_nxt = res_new;
    end else if (push) begin
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd0) slot0_nxt = res_new;
      else               slot1_nxt = res_new;
    end else if (pop) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {7'd0, slot0_r.up, slot0_r.north, slot0_r.east};

  `G2E_ASSERT(a_cnt_max, cnt_r <= 2'd2, "output buffer overfilled")
  `G2E_ASSERT(a_out_src, $rose(out_tvalid) |-> $past(v_r[PIPE_LAT-1]),
              "result without a pipeline beat")
  `G2E_ASSERT(a_east_sat, out_tvalid |-> ($signed(out_tdata[34:0]) >= -35'sd13000000000),
              "east below limit")
  `G2E_ASSERT(a_north_sat, out_tvalid |-> ($signed(out_tdata[69:35]) <= 35'sd13000000000),
              "north above limit")
  `G2E_ASSERT(a_full_stall, (cnt_r == 2'd2) |-> !push, "push into a full buffer")

endmodule

@@ hdl/g2e_div_cell.sv @@
// One restoring division step: one quotient bit per cell
`timescale 1ns / 1ps

module g2e_div_cell #(
  parameter int RW = 32,
  parameter int QW = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rem_i,
  input  logic [QW-1:0] sh_i,
  input  logic [RW-1:0] d_i,
  output logic [RW-1:0] rem_o,
  output logic [QW-1:0] sh_o,
  output logic [RW-1:0] d_o
);

  logic [RW:0]   t;
  logic          ge;
  logic [RW-1:0] rem_nxt, rem_r, d_r;
  logic [QW-1:0] sh_nxt, sh_r;

  always_comb begin
    t       = {rem_i, sh_i[QW-1]};
    ge      = (t >= {1'b0, d_i});
    rem_nxt = ge ? RW'(t - {1'b0, d_i}) : t[RW-1:0];
    sh_nxt  = {sh_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
      d_r   <= d_i;
    end
  end

  assign rem_o = rem_r;
  assign sh_o  = sh_r;
  assign d_o   = d_r;

endmodule

@@ hdl/g2e_cordic_cell.sv @@
// One CORDIC rotation step in Q2.30, angle in 2^-32 turn
`timescale 1ns / 1ps

module g2e_cordic_cell import g2e_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] x_i,
  input  logic signed [32:0] y_i,
  input  logic signed [32:0] z_i,
  input  quad_t              q_i,
  output logic signed [32:0] x_o,
  output logic signed [32:0] y_o,
  output logic signed [32:0] z_o,
  output quad_t              q_o
);

  localparam logic signed [32:0] ANG = 33'(ATAN_TURN32[IDX]);

  logic signed [32:0] x_nxt, y_nxt, z_nxt, x_r, y_r, z_r;
  quad_t              q_r;

  always_comb begin
    if (!z_i[32]) begin
      x_nxt = x_i - (y_i >>> IDX);
      y_nxt = y_i + (x_i >>> IDX);
      z_nxt = z_i - ANG;
    end else begin
      x_nxt = x_i + (y_i >>> IDX);
      y_nxt = y_i - (x_i >>> IDX);
      z_nxt = z_i + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      q_r <= q_i;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
  assign q_o = q_r;

endmodule

@@ hdl/g2e_sqrt_cell.sv @@
// One bit-pair step of the integer square root
`timescale 1ns / 1ps

module g2e_sqrt_cell #(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] v_i,
  input  logic [63:0] res_i,
  output logic [63:0] v_o,
  output logic [63:0] res_o
);

  localparam logic [63:0] ONE = 64'd1 << (62 - 2 * IDX);

  logic [63:0] sum, v_nxt, res_nxt, v_r, res_r;

  always_comb begin
    sum = res_i + ONE;
    if (v_i >= sum) begin
      v_nxt   = v_i - sum;
      res_nxt = (res_i >> 1) + ONE;
    end else begin
      v_nxt   = v_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r   <= v_nxt;
      res_r <= res_nxt;
    end
  end

  assign v_o   = v_r;
  assign res_o = res_r;

endmodule

@@ hdl/g2e_trig.sv @@
// Angle to sine and cosine: range fold, binary-angle reciprocal multiply, CORDIC chain
`timescale 1ns / 1ps

module g2e_trig import g2e_pkg::*; #(
  parameter int STAGES = 32
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] deg7,
  output trig_t              trig
);

  logic [31:0] deg_u, r;
  logic [58:0] ph_nxt, ph_r;
  logic [59:0] pl_nxt, pl_r;

  always_comb begin
    deg_u  = deg7;
    r      = deg_u[31] ? (deg_u + DEG7_TURN) : deg_u;
    ph_nxt = {27'd0, r} * {32'd0, BAM_K_HI};
    pl_nxt = {28'd0, r} * {32'd0, BAM_K_LO};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r <= ph_nxt;
      pl_r <= pl_nxt;
    end
  end

  // binary angle: scaled product with the rounding bias folded in
  logic [108:0] tot;
  logic [31:0]  bam_r;

  always_comb begin
    tot = {ph_r, 50'd0} + {27'd0, pl_r, 22'd0} + BAM_BIAS;
  end

  always_ff @(posedge clk) begin
    if (en) bam_r <= tot[107:76];
  end

  // fold to the nearest quarter turn
  logic [31:0]        qsum, resid;
  logic signed [32:0] z0_nxt, x0_r, y0_r, z0_r;
  quad_t              q0_nxt, q0_r;

  always_comb begin
    qsum   = bam_r + 32'h2000_0000;
    q0_nxt = quad_t'(qsum[31:30]);
    resid  = bam_r - {qsum[31:30], 30'd0};
    z0_nxt = {resid[31], resid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= CORDIC_GAIN;
      y0_r <= '0;
      z0_r <= z0_nxt;
      q0_r <= q0_nxt;
    end
  end

  logic signed [32:0] cx [STAGES+1];
  logic signed [32:0] cy [STAGES+1];
  logic signed [32:0] cz [STAGES];
  quad_t              cq [STAGES+1];

  assign cx[0] = x0_r;
  assign cy[0] = y0_r;
  assign cz[0] = z0_r;
  assign cq[0] = q0_r;

  for (genvar k = 0; k < STAGES; k++) begin : g_rot
    if (k < STAGES - 1) begin : g_mid
      g2e_cordic_cell #(.IDX(k)) u_cell (
        .clk, .en, .x_i(cx[k]), .y_i(cy[k]), .z_i(cz[k]), .q_i(cq[k]),
        .x_o(cx[k+1]), .y_o(cy[k+1]), .z_o(cz[k+1]), .q_o(cq[k+1])
      );
    end else begin : g_end
      g2e_cordic_cell #(.IDX(k)) u_cell (
        .clk, .en, .x_i(cx[k]), .y_i(cy[k]), .z_i(cz[k]), .q_i(cq[k]),
        .x_o(cx[k+1]), .y_o(cy[k+1]), .z_o(), .q_o(cq[k+1])
      );
    end
  end

  trig_t trig_nxt, trig_r;

  always_comb begin
    unique case (cq[STAGES])
      QUAD_0: begin trig_nxt.c = cx[STAGES];  trig_nxt.s = cy[STAGES];  end
      QUAD_1: begin trig_nxt.c = -cy[STAGES]; trig_nxt.s = cx[STAGES];  end
      QUAD_2: begin trig_nxt.c = -cx[STAGES]; trig_nxt.s = -cy[STAGES]; end
      QUAD_3: begin trig_nxt.c = cy[STAGES];  trig_nxt.s = -cx[STAGES]; end
      default: begin trig_nxt.c = cx[STAGES]; trig_nxt.s = cy[STAGES];  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) trig_r <= trig_nxt;
  end

  assign trig = trig_r;

endmodule

@@ hdl/g2e_ecef.sv @@
// Geodetic to ECEF: prime vertical radius by root and divider chains
`timescale 1ns / 1ps

module g2e_ecef import g2e_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  trig_t              lat,
  input  trig_t              lon,
  input  logic signed [27:0] h,
  output logic signed [35:0] px,
  output logic signed [35:0] py,
  output logic signed [35:0] pz,
  output trig_t              lat_o,
  output trig_t              lon_o
);

  side_t side_r [ECEF_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= '{lat: lat, lon: lon, h: h};
      for (int k = 1; k < ECEF_LAT; k++) side_r[k] <= side_r[k-1];
    end
  end

  // sin^2 and 1 - e2 sin^2
  logic signed [65:0] ss;
  logic [65:0]        ssr;
  logic [32:0]        s2q_r;
  logic [57:0]        e2s;
  logic [63:0]        w_r;

  always_comb begin
    ss  = lat.s * lat.s;
    ssr = ss + 66'd536870912;
    e2s = E2_Q32 * s2q_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2q_r <= ssr[62:30];
      w_r   <= (64'd1 << 62) - 64'(e2s);
    end
  end

  logic [63:0] sv [SQRT_STEPS];
  logic [63:0] sr [SQRT_STEPS+1];

  assign sv[0] = w_r;
  assign sr[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    if (k < SQRT_STEPS - 1) begin : g_mid
      g2e_sqrt_cell #(.IDX(k)) u_cell (
        .clk, .en, .v_i(sv[k]), .res_i(sr[k]), .v_o(sv[k+1]), .res_o(sr[k+1])
      );
    end else begin : g_end
      g2e_sqrt_cell #(.IDX(k)) u_cell (
        .clk, .en, .v_i(sv[k]), .res_i(sr[k]), .v_o(), .res_o(sr[k+1])
      );
    end
  end

  logic [31:0] rt, rt_r;
  logic [63:0] num_r;

  assign rt = sr[SQRT_STEPS][31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      rt_r  <= rt;
      num_r <= {A_MM, 31'd0} + 64'(rt[31:1]);
    end
  end

  logic [31:0]          nrem [NDIV_BITS];
  logic [31:0]          nd   [NDIV_BITS];
  logic [NDIV_BITS-1:0] nsh  [NDIV_BITS+1];

  assign nrem[0] = {1'b0, num_r[63:33]};
  assign nsh[0]  = num_r[32:0];
  assign nd[0]   = rt_r;

  for (genvar k = 0; k < NDIV_BITS; k++) begin : g_div
    if (k < NDIV_BITS - 1) begin : g_mid
      g2e_div_cell #(.RW(32), .QW(NDIV_BITS)) u_cell (
        .clk, .en, .rem_i(nrem[k]), .sh_i(nsh[k]), .d_i(nd[k]),
        .rem_o(nrem[k+1]), .sh_o(nsh[k+1]), .d_o(nd[k+1])
      );
    end else begin : g_end
      g2e_div_cell #(.RW(32), .QW(NDIV_BITS)) u_cell (
        .clk, .en, .rem_i(nrem[k]), .sh_i(nsh[k]), .d_i(nd[k]),
        .rem_o(), .sh_o(nsh[k+1]), .d_o()
      );
    end
  end

  side_t              s3, s4;
  logic [32:0]        n;
  logic signed [34:0] nh, zt_nxt;
  logic [57:0]        ne2p;
  logic [57:0]        ne2r;
  logic signed [39:0] nc_r, zt_r, px_nxt, py_nxt, pz_nxt;
  logic signed [35:0] px_r, py_r, pz_r;

  always_comb begin
    s3     = side_r[ECEF_LAT-3];
    s4     = side_r[ECEF_LAT-2];
    n      = nsh[NDIV_BITS];
    nh     = $signed({2'b00, n}) + 35'(s3.h);
    ne2p   = n * E2_Q32;
    ne2r   = ne2p + 58'h8000_0000;
    zt_nxt = $signed({2'b00, n}) - $signed({9'd0, ne2r[57:32]}) + 35'(s3.h);
    px_nxt = mulq(40'(nc_r), 34'(s4.lon.c));
    py_nxt = mulq(40'(nc_r), 34'(s4.lon.s));
    pz_nxt = mulq(40'(zt_r), 34'(s4.lat.s));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nc_r <= mulq(40'(nh), 34'(s3.lat.c));
      zt_r <= 40'(zt_nxt);
      px_r <= px_nxt[35:0];
      py_r <= py_nxt[35:0];
      pz_r <= pz_nxt[35:0];
    end
  end

  assign px    = px_r;
  assign py    = py_r;
  assign pz    = pz_r;
  assign lat_o = side_r[ECEF_LAT-1].lat;
  assign lon_o = side_r[ECEF_LAT-1].lon;

endmodule
